// ----- hdl/checked_integer_power_core_macros.svh -----
// ----------------------------------------------------------------------------
// checked_integer_power_core_macros.svh
// Assertion macros used by the checked integer power checker.
// ----------------------------------------------------------------------------
`ifndef CHECKED_INTEGER_POWER_CORE_MACROS_SVH
`define CHECKED_INTEGER_POWER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CIP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checked_integer_power_core: assertion failed");

// Next-cycle implication, disabled in reset.
`define CIP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checked_integer_power_core: assertion failed");

`endif

// ----- hdl/cip_pkg.sv -----
// ----------------------------------------------------------------------------
// cip_pkg
// Types and constants for the checked integer power core.
// ----------------------------------------------------------------------------
package cip_pkg;

    localparam int unsigned DataW = 32;

    typedef struct packed {
        logic signed [DataW-1:0] base;
        logic        [DataW-1:0] exponent;
    } req_t;

    typedef struct packed {
        logic signed [DataW-1:0] value;
        logic                    ok;
    } rsp_t;

    typedef struct packed {
        logic valid;
        rsp_t rsp;
    } fin_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam logic signed [DataW-1:0] ValOne    = DataW'(1);
    localparam logic signed [DataW-1:0] ValZero   = '0;
    localparam logic signed [DataW-1:0] ValMinus1 = '1;

endpackage

// ----- hdl/cip_mul.sv -----
// ----------------------------------------------------------------------------
// cip_mul
// Shared signed 32x32 multiplier with signed 32-bit overflow detect.
// ----------------------------------------------------------------------------
module cip_mul
    import cip_pkg::*;
(
    input  logic signed [DataW-1:0] op_a,
    input  logic signed [DataW-1:0] op_b,
    output logic signed [DataW-1:0] prod,
    output logic                    ovf
);

    logic signed [2*DataW-1:0] full;
    logic        [DataW:0]     upper;

    assign full  = op_a * op_b;
    assign upper = full[2*DataW-1:DataW-1];
    assign prod  = full[DataW-1:0];
    assign ovf   = !((&upper) || (~|upper));

endmodule

// ----- hdl/cip_seq.sv -----
// ----------------------------------------------------------------------------
// cip_seq
// Square-and-multiply sequencer driving the shared multiplier.
// ----------------------------------------------------------------------------
module cip_seq
    import cip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output fin_t fin,
    input  logic take
);

    state_t                  state_reg, state_next;
    logic signed [DataW-1:0] acc_reg, acc_next;
    logic signed [DataW-1:0] sq_reg, sq_next;
    logic        [DataW-1:0] e_reg, e_next;
    logic                    mul_done_reg, mul_done_next;
    logic                    ok_reg, ok_next;

    logic                    sel_acc;
    logic signed [DataW-1:0] op_a;
    logic signed [DataW-1:0] prod;
    logic                    ovf;

    assign sel_acc = e_reg[0] && !mul_done_reg;
    assign op_a    = sel_acc ? acc_reg : sq_reg;

    cip_mul u_mul (
        .op_a (op_a),
        .op_b (sq_reg),
        .prod (prod),
        .ovf  (ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        sq_reg       <= sq_next;
        e_reg        <= e_next;
        mul_done_reg <= mul_done_next;
        ok_reg       <= ok_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        e_next        = e_reg;
        mul_done_next = mul_done_reg;
        ok_next       = ok_reg;
        req_ready     = 1'b0;
        fin.valid     = 1'b0;
        fin.rsp.value = acc_reg;
        fin.rsp.ok    = ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ok_next       = 1'b1;
                    acc_next      = ValOne;
                    sq_next       = req.base;
                    e_next        = req.exponent;
                    mul_done_next = 1'b0;
                    state_next    = ST_DONE;
                    if (req.exponent == '0)
                    begin
                        acc_next = ValOne;
                    end
                    else if (req.base == ValZero)
                    begin
                        acc_next = ValZero;
                    end
                    else if (req.base == ValOne)
                    begin
                        acc_next = ValOne;
                    end
                    else if (req.base == ValMinus1)
                    begin
                        acc_next = req.exponent[0] ? ValMinus1 : ValOne;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                if (sel_acc)
                begin
                    if (ovf)
                    begin
                        ok_next    = 1'b0;
                        acc_next   = ValZero;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        acc_next      = prod;
                        mul_done_next = 1'b1;
                    end
                end
                else if (e_reg[DataW-1:1] == '0)
                begin
                    state_next = ST_DONE;
                end
                else if (ovf)
                begin
                    ok_next    = 1'b0;
                    acc_next   = ValZero;
                    state_next = ST_DONE;
                end
                else
                begin
                    sq_next       = prod;
                    e_next        = {1'b0, e_reg[DataW-1:1]};
                    mul_done_next = 1'b0;
                end
            end

            ST_DONE:
            begin
                fin.valid = 1'b1;
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/checked_integer_power_core.sv -----
// ----------------------------------------------------------------------------
// checked_integer_power_core
// Checked signed 32-bit integer power by square-and-multiply.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req) carries one beat per power:
//   a signed base and an unsigned exponent. rsp channel
//   (rsp_valid/rsp_ready/rsp) returns one beat per request: the value and
//   an ok flag; on signed 32-bit overflow ok is 0 and value is 0.
//   One request is worked at a time; req_ready is high only while idle.
//   Zero exponent and bases 0, 1 and -1 skip the multiplier and go from
//   idle straight to the done state. Other bases do one multiply or
//   squaring per step on the single shared 32x32 multiplier, a step to see
//   the last exponent bit when nothing overflows, and a closing step; the
//   walk stops at the first overflow, which for magnitude two or more comes
//   by the fifth squaring. req_ready returns the cycle after the result
//   leaves the sequencer.
//   The result sits in an output register: a new request may be taken
//   while it waits, and a stalled rsp holds its beat until rsp_ready.
//   Reset clears the control state and drops any beat in flight.
// ----------------------------------------------------------------------------
module checked_integer_power_core
    import cip_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    fin_t fin;
    logic take;
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg, rsp_next;

    assign take = !rsp_valid_reg || rsp_ready;

    cip_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .fin       (fin),
        .take      (take)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (take)
        begin
            rsp_valid_next = fin.valid;
            if (fin.valid)
            begin
                rsp_next = fin.rsp;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/cip_checker.sv -----
// ----------------------------------------------------------------------------
// cip_checker
// Port-level checks for the checked integer power core.
// ----------------------------------------------------------------------------
`include "checked_integer_power_core_macros.svh"

module cip_checker
    import cip_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    `CIP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
    `CIP_ASSERT_IMPL(a_ovf_zero, rsp_valid && !rsp.ok, rsp.value == ValZero)
    `CIP_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
    `CIP_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid && $stable(req))

endmodule

bind checked_integer_power_core cip_checker u_cip_checker (.*);
